// ----- hw/rtl/bmx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_pkg: shared types, constants and helpers for the bit-mask expander
// Channel counts, controller states, command/status bundles, mask functions.
// ----------------------------------------------------------------------------
package bmx_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int WORD_W       = 16;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

	localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(MAX_CHANNELS);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic run_nonempty;
		logic last_beat;
	} dp_status_t;

	// Clamp the register into 1..MAX_CHANNELS.
	function automatic logic [CNT_W-1:0] used_channels(input logic [CNT_W-1:0] cfg);
		logic [CNT_W-1:0] n;
		n = cfg;
		if (n == '0) n = CNT_W'(1);
		if (n > CNT_W'(MAX_CHANNELS)) n = CNT_W'(MAX_CHANNELS);
		return n;
	endfunction

	// Bits below n set.
	function automatic logic [MAX_CHANNELS-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [MAX_CHANNELS:0] t;
		t = ((MAX_CHANNELS+1)'(1) << n) - (MAX_CHANNELS+1)'(1);
		return t[MAX_CHANNELS-1:0];
	endfunction

	// Bits strictly above ch set.
	function automatic logic [MAX_CHANNELS-1:0] above_mask(input logic [CH_W-1:0] ch);
		logic [MAX_CHANNELS:0] t;
		t = ((MAX_CHANNELS+1)'(2) << ch) - (MAX_CHANNELS+1)'(1);
		return ~t[MAX_CHANNELS-1:0];
	endfunction

	// Index of the lowest set bit, MAX_CHANNELS when none.
	function automatic logic [CNT_W-1:0] lowest_set(input logic [MAX_CHANNELS-1:0] m);
		logic [CNT_W-1:0] r;
		r = CNT_W'(MAX_CHANNELS);
		for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
			if (m[i]) r = CNT_W'(i);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/bmx_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_if: valid/ready channels of the bit-mask expander
// One interface for raw input words, one for dense result beats.
// ----------------------------------------------------------------------------
interface bmx_word_if;
	logic                         valid;
	logic                         ready;
	logic [bmx_pkg::WORD_W-1:0]   word;
	logic                         last_in_buffer;

	modport source (output valid, output word, output last_in_buffer, input ready);
	modport sink   (input valid, input word, input last_in_buffer, output ready);
endinterface

interface bmx_result_if;
	logic                         valid;
	logic                         ready;
	logic [bmx_pkg::WORD_W-1:0]   value;
	logic [bmx_pkg::CH_W-1:0]     channel;
	logic                         event_end;
	logic                         truncated;
	logic                         run_end;

	modport source (output valid, output value, output channel, output event_end,
		output truncated, output run_end, input ready);
	modport sink   (input valid, input value, input channel, input event_end,
		input truncated, input run_end, output ready);
endinterface

// ----- hw/rtl/bitmask_event_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmask_event_expander: zero-suppression bit-mask expander, top level
// The first result beat is offered in the cycle after the word is accepted.
// Each word causes 0..16 result beats; the controller holds the input
//   until the last beat of the run is taken.
// Reset: arst_n clears the event state, the channel count returns to 16.
// ----------------------------------------------------------------------------
module bitmask_event_expander (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [bmx_pkg::CNT_W-1:0]  cfg_wdata,
	bmx_word_if.sink                   word_ch,
	bmx_result_if.source               result_ch
);

	// Words arrive as a header mask followed by one value per live channel.
	// Each accepted word is decoded into a contiguous run of channels; the
	// datapath then emits one dense beat per channel while the controller
	// keeps the input stalled. A header that closes a buffer produces an
	// empty run and the word is simply dropped.

	bmx_pkg::ctrl_cmd_t  cmd;
	bmx_pkg::dp_status_t status;

	bmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (word_ch.valid),
		.in_ready  (word_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath owns the event mask, the channel pointer and the run counter.
	bmx_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.word           (word_ch.word),
		.last_in_buffer (word_ch.last_in_buffer),
		.value          (result_ch.value),
		.channel        (result_ch.channel),
		.event_end      (result_ch.event_end),
		.truncated      (result_ch.truncated),
		.run_end        (result_ch.run_end)
	);

`ifndef ASSERT_OFF
	// hold the input while a run is being emitted
	a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> !word_ch.ready)
		else $error("input ready while result beats pending");

	a_event_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.event_end |-> result_ch.run_end)
		else $error("event end not on last beat of run");

	// advance one channel per beat inside a run
	a_channel_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.ready && !result_ch.run_end |=>
		result_ch.valid &&
		result_ch.channel == $past(result_ch.channel) + bmx_pkg::CH_W'(1))
		else $error("channel did not advance within run");

	a_truncated_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.truncated |-> result_ch.value == '0)
		else $error("truncated beat carries a value");
`endif

endmodule

// ----- hw/rtl/bmx_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_ctrl: controller of the bit-mask expander
// Accepts one word when idle, then walks the run of result beats.
// ----------------------------------------------------------------------------
module bmx_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bmx_pkg::dp_status_t  status,
	output bmx_pkg::ctrl_cmd_t   cmd
);

	bmx_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		case (state_q)
			bmx_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && status.run_nonempty) state_d = bmx_pkg::ST_EMIT;
			end
			bmx_pkg::ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready;
				// drop back once the final beat of the run is taken
				if (out_ready && status.last_beat) state_d = bmx_pkg::ST_IDLE;
			end
			default: begin
				state_d = bmx_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/bmx_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_datapath: event state, run planning and beat generation
// Decodes each word into a channel run [start, stop) and steps through it.
// ----------------------------------------------------------------------------
module bmx_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bmx_pkg::ctrl_cmd_t            cmd,
	output bmx_pkg::dp_status_t           status,
	input  logic                          cfg_wen,
	input  logic [bmx_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic [bmx_pkg::WORD_W-1:0]    word,
	input  logic                          last_in_buffer,
	output logic [bmx_pkg::WORD_W-1:0]    value,
	output logic [bmx_pkg::CH_W-1:0]      channel,
	output logic                          event_end,
	output logic                          truncated,
	output logic                          run_end
);

	// event state
	logic [bmx_pkg::CNT_W-1:0]        cfg_q;
	logic [bmx_pkg::MAX_CHANNELS-1:0] mask_q;
	logic [bmx_pkg::CH_W-1:0]         next_q;
	logic                             in_event_q;

	// run state
	logic [bmx_pkg::CNT_W-1:0]        cur_q, stop_q;
	logic                             has_word_q, trunc_q;
	logic [bmx_pkg::WORD_W-1:0]       word_q;

	logic [bmx_pkg::CNT_W-1:0]        n;
	logic [bmx_pkg::MAX_CHANNELS-1:0] hdr_mask, rest;
	logic [bmx_pkg::CNT_W-1:0]        f_hdr, f_rest;
	logic [bmx_pkg::CNT_W-1:0]        start_d, stop_d;
	logic                             has_word_d, trunc_d;
	logic [bmx_pkg::MAX_CHANNELS-1:0] mask_d;
	logic [bmx_pkg::CH_W-1:0]         next_d;
	logic                             in_event_d;

	assign n        = bmx_pkg::used_channels(cfg_q);
	assign hdr_mask = word & bmx_pkg::low_mask(n);
	assign rest     = mask_q & bmx_pkg::above_mask(next_q);
	assign f_hdr    = bmx_pkg::lowest_set(hdr_mask);
	assign f_rest   = bmx_pkg::lowest_set(rest);

	always_comb begin
		start_d    = '0;
		stop_d     = '0;
		has_word_d = 1'b0;
		trunc_d    = 1'b0;
		mask_d     = mask_q;
		next_d     = next_q;
		in_event_d = in_event_q;
		if (!in_event_q) begin
			if (last_in_buffer) begin
				stop_d = '0;
			end else if (hdr_mask == '0) begin
				stop_d = n;
			end else begin
				// zeros ahead of the first live channel, then wait for values
				stop_d     = f_hdr;
				mask_d     = hdr_mask;
				next_d     = f_hdr[bmx_pkg::CH_W-1:0];
				in_event_d = 1'b1;
			end
		end else begin
			start_d    = {1'b0, next_q};
			has_word_d = 1'b1;
			if (rest == '0 || last_in_buffer) begin
				stop_d     = n;
				trunc_d    = (rest != '0);
				mask_d     = '0;
				next_d     = '0;
				in_event_d = 1'b0;
			end else begin
				stop_d = f_rest;
				next_d = f_rest[bmx_pkg::CH_W-1:0];
			end
		end
	end

	assign status.run_nonempty = (stop_d != start_d);
	assign status.last_beat    = (cur_q + bmx_pkg::CNT_W'(1) == stop_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= bmx_pkg::CFG_RESET;
			mask_q     <= '0;
			next_q     <= '0;
			in_event_q <= 1'b0;
			cur_q      <= '0;
			stop_q     <= '0;
			has_word_q <= 1'b0;
			trunc_q    <= 1'b0;
		end else if (cfg_wen) begin
			// abandon any open event
			cfg_q      <= cfg_wdata;
			mask_q     <= '0;
			next_q     <= '0;
			in_event_q <= 1'b0;
		end else if (cmd.load) begin
			mask_q     <= mask_d;
			next_q     <= next_d;
			in_event_q <= in_event_d;
			cur_q      <= start_d;
			stop_q     <= stop_d;
			has_word_q <= has_word_d;
			trunc_q    <= trunc_d;
		end else if (cmd.advance) begin
			cur_q      <= cur_q + bmx_pkg::CNT_W'(1);
			has_word_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) word_q <= word;
	end

	assign value     = has_word_q ? word_q : '0;
	assign channel   = cur_q[bmx_pkg::CH_W-1:0];
	assign run_end   = status.last_beat;
	assign event_end = status.last_beat && (stop_q == n);
	assign truncated = trunc_q && !has_word_q;

endmodule

// ----- bench/tb_bitmask_event_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmask_event_expander: self-checking bench for the bit-mask expander
// Drives header/value word streams through the valid/ready input channel,
// predicts the dense per-channel result beats in a scoreboard class and
// compares every accepted result beat field by field against the oldest
// prediction. Sweeps the channel count over its extremes between phases,
// with random idling on both sides and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_bitmask_event_expander;

	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 8;

	// One dense result beat as the block presents it.
	typedef struct packed {
		logic [bmx_pkg::WORD_W-1:0] value;
		logic [bmx_pkg::CH_W-1:0]   channel;
		logic                       event_end;
		logic                       truncated;
		logic                       run_end;
	} dense_beat_t;

	// One raw input word.
	typedef struct packed {
		logic [bmx_pkg::WORD_W-1:0] word;
		logic                       last;
	} raw_word_t;

	// Scoreboard: tracks event state on its own and queues the dense beats
	// that each accepted word must produce.
	class expander_scoreboard;
		dense_beat_t                pending_q[$];
		logic [bmx_pkg::CNT_W-1:0]  channels_reg;
		logic [bmx_pkg::WORD_W-1:0] evt_mask;
		int                         next_ch;
		bit                         in_evt;
		int                         errors;

		function new();
			channels_reg = bmx_pkg::CFG_RESET;
			evt_mask     = '0;
			next_ch      = 0;
			in_evt       = 1'b0;
			errors       = 0;
		endfunction

		// A register write drops any event in progress.
		function void set_channels(logic [bmx_pkg::CNT_W-1:0] v);
			channels_reg = v;
			evt_mask     = '0;
			next_ch      = 0;
			in_evt       = 1'b0;
		endfunction

		function int used_count();
			int n;
			n = channels_reg;
			if (n < 1) n = 1;
			if (n > bmx_pkg::MAX_CHANNELS) n = bmx_pkg::MAX_CHANNELS;
			return n;
		endfunction

		function int lowest_bit(logic [bmx_pkg::WORD_W-1:0] m);
			int r;
			r = bmx_pkg::MAX_CHANNELS;
			for (int i = bmx_pkg::MAX_CHANNELS - 1; i >= 0; i--) begin
				if (m[i]) r = i;
			end
			return r;
		endfunction

		function void add_beat(logic [bmx_pkg::WORD_W-1:0] v, int ch, bit last_ch,
				bit trunc);
			dense_beat_t b;
			b.value     = v;
			b.channel   = bmx_pkg::CH_W'(ch);
			b.event_end = last_ch;
			b.truncated = trunc;
			b.run_end   = 1'b0;
			pending_q.push_back(b);
		endfunction

		function void fill_zero(int from, int n, bit trunc);
			for (int c = from; c < n; c++) add_beat('0, c, c == n - 1, trunc);
		endfunction

		// Note an accepted word and queue the beats it decides.
		function void note_word(logic [bmx_pkg::WORD_W-1:0] w, logic last);
			int                         n;
			int                         f;
			int                         ch;
			int                         k0;
			logic [bmx_pkg::WORD_W-1:0] m;
			logic [bmx_pkg::WORD_W-1:0] rest;
			dense_beat_t                b;
			n  = used_count();
			k0 = pending_q.size();
			if (!in_evt) begin
				// Awaiting a header; a header that ends the buffer is dropped.
				if (!last) begin
					m = '0;
					for (int i = 0; i < n; i++) m[i] = w[i];
					if (m == '0) begin
						fill_zero(0, n, 1'b0);
					end else begin
						f = lowest_bit(m);
						for (int c = 0; c < f; c++) add_beat('0, c, 1'b0, 1'b0);
						evt_mask = m;
						next_ch  = f;
						in_evt   = 1'b1;
					end
				end
			end else begin
				ch   = next_ch;
				rest = evt_mask;
				for (int c = 0; c <= ch; c++) rest[c] = 1'b0;
				if (rest == '0) begin
					add_beat(w, ch, ch == n - 1, 1'b0);
					fill_zero(ch + 1, n, 1'b0);
					in_evt = 1'b0;
				end else if (last) begin
					// Buffer ended early: zero-fill the rest as truncated.
					add_beat(w, ch, 1'b0, 1'b0);
					fill_zero(ch + 1, n, 1'b1);
					in_evt = 1'b0;
				end else begin
					f = lowest_bit(rest);
					add_beat(w, ch, 1'b0, 1'b0);
					for (int c = ch + 1; c < f; c++) add_beat('0, c, 1'b0, 1'b0);
					next_ch = f;
				end
				if (!in_evt) begin
					evt_mask = '0;
					next_ch  = 0;
				end
			end
			if (pending_q.size() > k0) begin
				b = pending_q.pop_back();
				b.run_end = 1'b1;
				pending_q.push_back(b);
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(dense_beat_t got);
			dense_beat_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected beat ch %0d value %h", got.channel, got.value));
			end else begin
				want = pending_q.pop_front();
				if (got.value !== want.value || got.channel !== want.channel ||
						got.event_end !== want.event_end || got.truncated !== want.truncated ||
						got.run_end !== want.run_end) begin
					report($sformatf({"got/exp ch %0d/%0d value %h/%h end %b/%b ",
						"trunc %b/%b run_end %b/%b"}, got.channel, want.channel,
						got.value, want.value, got.event_end, want.event_end,
						got.truncated, want.truncated, got.run_end, want.run_end));
				end
			end
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wen;
	logic [bmx_pkg::CNT_W-1:0] cfg_wdata;

	bmx_word_if   word_if ();
	bmx_result_if res_if ();

	expander_scoreboard sb;
	raw_word_t          stim_q[$];
	bit                 idle_on;
	bit                 hold_req;
	int                 quiet_cycles;

	bitmask_event_expander uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.word_ch   (word_if.sink),
		.result_ch (res_if.source)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Stimulus builders: append words to stim_q, return how many count
	// toward the item budget (dropped headers do not).
	// ------------------------------------------------------------------
	function automatic void add_stim(logic [bmx_pkg::WORD_W-1:0] w, logic last);
		raw_word_t s;
		s.word = w;
		s.last = last;
		stim_q.push_back(s);
	endfunction

	// Bias values toward the extremes now and then.
	function automatic logic [bmx_pkg::WORD_W-1:0] rand_value();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		return bmx_pkg::WORD_W'($urandom);
	endfunction

	// One well-formed event, sometimes cut short by a buffer end.
	function automatic int queue_event(int n);
		logic [bmx_pkg::WORD_W-1:0] hdr;
		int                         sel;
		int                         k;
		int                         cut;
		int                         cnt;
		logic                       last;
		sel = $urandom_range(0, 9);
		hdr = bmx_pkg::WORD_W'($urandom);
		if (sel == 0) begin
			for (int i = 0; i < n; i++) hdr[i] = 1'b0;
		end else if (sel == 1) begin
			hdr = '1;
		end
		// Occasionally place the header at the buffer end; it is dropped.
		if ($urandom_range(0, 19) == 0) begin
			add_stim(hdr, 1'b1);
			return 0;
		end
		add_stim(hdr, 1'b0);
		cnt = 1;
		k   = 0;
		for (int i = 0; i < n; i++) k += hdr[i];
		cut = (k > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(0, k - 2) : -1;
		for (int i = 0; i < k; i++) begin
			last = (i == cut) || (i == k - 1 && $urandom_range(0, 3) == 0);
			add_stim(rand_value(), last);
			cnt++;
			if (i == cut) break;
		end
		return cnt;
	endfunction

	// Random junk, then a buffer end to bring framing back to a header.
	function automatic int queue_noise();
		int m;
		m = $urandom_range(1, 3);
		for (int i = 0; i < m; i++) begin
			add_stim(bmx_pkg::WORD_W'($urandom), 1'($urandom_range(0, 1)));
		end
		add_stim(bmx_pkg::WORD_W'($urandom), 1'b1);
		return m + 1;
	endfunction

	function automatic void build_phase(int n, int target);
		int cnt;
		cnt = 0;
		while (cnt < target) begin
			if ($urandom_range(0, 9) == 0) cnt += queue_noise();
			else cnt += queue_event(n);
		end
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Offer one word, optionally after an idle burst, and hold it until taken.
	task automatic send_word(raw_word_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			word_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		word_if.valid          <= 1'b1;
		word_if.word           <= s.word;
		word_if.last_in_buffer <= s.last;
		@(posedge clk);
		while (!word_if.ready) @(posedge clk);
		sb.note_word(s.word, s.last);
	endtask

	task automatic drive_stim();
		foreach (stim_q[i]) send_word(stim_q[i]);
		word_if.valid <= 1'b0;
		stim_q.delete();
	endtask

	// Write the channel count once the block has drained; a word that
	// produced no beats may still be in flight, so wait before the write.
	task automatic write_channels(logic [bmx_pkg::CNT_W-1:0] v);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_channels(v);
	endtask

	// Result side: random stall bursts, plus one long hold-off on request
	// so the block backs up and stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				res_if.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Check every result beat taken at this edge.
	always @(posedge clk) begin
		dense_beat_t got;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.value     = res_if.value;
			got.channel   = res_if.channel;
			got.event_end = res_if.event_end;
			got.truncated = res_if.truncated;
			got.run_end   = res_if.run_end;
			sb.check_result(got);
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((word_if.valid === 1'b1 && word_if.ready === 1'b1) ||
				(res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL bitmask_event_expander");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [bmx_pkg::CNT_W-1:0] phase_cfg [PHASES];
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_wen                = 1'b0;
		cfg_wdata              = '0;
		word_if.valid          = 1'b0;
		word_if.word           = '0;
		word_if.last_in_buffer = 1'b0;
		res_if.ready           = 1'b0;
		idle_on                = 1'b1;
		hold_req               = 1'b0;
		quiet_cycles           = 0;
		sb                     = new();

		// Extremes of the count first, then a mix; the final phase uses the
		// full count with no idling.
		phase_cfg[0] = bmx_pkg::CNT_W'(1);
		phase_cfg[1] = bmx_pkg::CNT_W'(0);
		phase_cfg[2] = bmx_pkg::CNT_W'(31);
		phase_cfg[3] = bmx_pkg::CNT_W'(17);
		phase_cfg[4] = bmx_pkg::CNT_W'(2);
		phase_cfg[5] = bmx_pkg::CNT_W'(9);
		phase_cfg[6] = bmx_pkg::CNT_W'($urandom_range(0, 31));
		phase_cfg[7] = bmx_pkg::CNT_W'(16);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset count of sixteen channels.
		add_stim(16'h0000, 1'b0);   // empty header: sixteen zero beats
		add_stim(16'hFFFF, 1'b1);   // header at buffer end: dropped
		add_stim(16'h0001, 1'b0);   // channel 0 set: nothing until the value
		add_stim(16'hFFFF, 1'b0);
		add_stim(16'h8000, 1'b0);   // only the top channel set
		add_stim(16'h1234, 1'b1);   // buffer ends exactly at the event end
		add_stim(16'hA5A5, 1'b0);   // sparse mask, gaps between values
		add_stim(16'h0000, 1'b0);
		add_stim(16'hFFFF, 1'b0);
		add_stim(16'hAAAA, 1'b0);
		add_stim(16'h5555, 1'b0);
		add_stim(16'h8001, 1'b0);
		add_stim(16'h7FFE, 1'b0);
		add_stim(16'h0F0F, 1'b0);
		add_stim(16'hF0F0, 1'b0);
		add_stim(16'h0F0F, 1'b0);   // buffer ends mid-event: truncated fill
		add_stim(16'hBEEF, 1'b0);
		add_stim(16'hCAFE, 1'b1);
		drive_stim();

		for (int p = 0; p < PHASES; p++) begin
			write_channels(phase_cfg[p]);
			if (p == PHASES - 1) idle_on = 1'b0;
			build_phase(sb.used_count(), 32);
			if (p == 2) hold_req = 1'b1;
			drive_stim();
		end

		// Drain, then give trailing beats a chance to show up.
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("PASS bitmask_event_expander");
		end else begin
			$display("FAIL bitmask_event_expander");
		end
		$finish;
	end

endmodule
